>>> hdl/brpd_pkg.sv
// Shared types and constants of the byte run-length pair decoder.
`default_nettype none

package brpd_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 64;
  localparam int NBYTE_W = 4;
  localparam int STAT_W  = 3;
  localparam int TOTAL_W = 32;

  // Defaults for top-level parameters
  localparam int DEF_BYTES_PER_WORD = 8;
  localparam int DEF_QUEUE_DEPTH    = 4;

  // Status codes of a result word
  localparam logic [STAT_W-1:0] ST_RUNNING    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DONE_OK    = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_COUNT = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXCEEDS    = 3'd3;
  localparam logic [STAT_W-1:0] ST_TRUNCATED  = 3'd4;
  localparam logic [STAT_W-1:0] ST_MISMATCH   = 3'd5;

  // Command from the classifier to the expander
  typedef struct packed {
    logic               is_run;  // 1: expand a run, 0: one status-only word
    logic [STAT_W-1:0]  status;  // status for a status-only word
    logic [BYTE_W-1:0]  value;   // run value byte
    logic [BYTE_W-1:0]  count;   // run length, never zero for a run
    logic [TOTAL_W-1:0] total;   // total before the run, or total to report
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/brpd_if.sv
// Channel interfaces: compressed input words and decoded result words.
`default_nettype none

interface brpd_in_if import brpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface brpd_out_if import brpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  data_word;
  logic [NBYTE_W-1:0] byte_count;
  logic               run_last;
  logic [STAT_W-1:0]  status;
  logic [TOTAL_W-1:0] total_bytes;

  modport source (output valid, output data_word, output byte_count, output run_last,
                  output status, output total_bytes, input ready);
  modport sink   (input valid, input data_word, input byte_count, input run_last,
                  input status, input total_bytes, output ready);
endinterface

`default_nettype wire

>>> hdl/byte_rle_pair_decoder.sv
// Top level of the byte run-length pair decoder.
//
//   channel   dir  handshake     word contents
//   in_ch     in   valid/ready   func, data_byte
//   out_ch    out  valid/ready   data_word, byte_count, run_last, status, total_bytes
//   cfg       in   cfg_we        cfg_data -> size register
//
// The classifier takes one input word per cycle while the command queue has room.
// A run of N bytes yields ceil(N / BYTES_PER_WORD) words at one word per cycle from
// the expander while the output is ready; a status-only result yields one word. A pair
// needs two input words, a count and then a value.
// Reset is synchronous and clears stream state, queue and the size register (to 0).
// Output stalls back up through the queue; input stalls when the queue is full.
`default_nettype none

module byte_rle_pair_decoder import brpd_pkg::*; #(
  parameter int BYTES_PER_WORD = DEF_BYTES_PER_WORD,
  parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  brpd_in_if.sink          in_ch,
  brpd_out_if.source       out_ch
);

  cmd_t push_cmd, head_cmd;
  logic push, full, head_valid, pop;

  brpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .cmd_push (push),
    .cmd      (push_cmd),
    .cmd_full (full)
  );

  brpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (push_cmd),
    .full   (full),
    .rvalid (head_valid),
    .rdata  (head_cmd),
    .pop    (pop)
  );

  brpd_back #(
    .BYTES_PER_WORD (BYTES_PER_WORD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> hdl/brpd_front.sv
// Classifier: takes compressed words, tracks stream state, issues commands.
`default_nettype none

module brpd_front import brpd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_data,
  brpd_in_if.sink           in_ch,
  output logic              cmd_push,
  output cmd_t              cmd,
  input  wire logic         cmd_full
);

  logic [TOTAL_W-1:0] size_target;
  logic               count_pending, count_pending_next;
  logic [BYTE_W-1:0]  run_count, run_count_next;
  logic [TOTAL_W-1:0] total_count, total_count_next;
  logic [STAT_W-1:0]  error_code, error_code_next;
  logic               accept;
  logic [TOTAL_W:0]   run_sum;

  assign in_ch.ready = !cmd_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign run_sum     = {1'b0, total_count} + {{(TOTAL_W+1-BYTE_W){1'b0}}, run_count};

  // Classify the accepted word
  always_comb begin
    count_pending_next = count_pending;
    run_count_next     = run_count;
    total_count_next   = total_count;
    error_code_next    = error_code;
    cmd_push           = 1'b0;
    cmd.is_run         = 1'b0;
    cmd.status         = error_code;
    cmd.value          = in_ch.data_byte;
    cmd.count          = run_count;
    cmd.total          = total_count;
    if (accept) begin
      if (in_ch.func) begin
        // end of stream: report outcome, back to a clean stream
        cmd_push = 1'b1;
        if (error_code != ST_RUNNING) begin
          cmd.status = error_code;
        end else if (count_pending) begin
          cmd.status = ST_TRUNCATED;
        end else if (total_count != size_target) begin
          cmd.status = ST_MISMATCH;
        end else begin
          cmd.status = ST_DONE_OK;
        end
        count_pending_next = 1'b0;
        run_count_next     = '0;
        total_count_next   = '0;
        error_code_next    = ST_RUNNING;
      end else if (error_code != ST_RUNNING) begin
        // sticky error: drop data
      end else if (size_target == '0) begin
        cmd_push        = 1'b1;
        cmd.status      = ST_EXCEEDS;
        error_code_next = ST_EXCEEDS;
      end else if (!count_pending) begin
        if (in_ch.data_byte == '0) begin
          cmd_push        = 1'b1;
          cmd.status      = ST_ZERO_COUNT;
          error_code_next = ST_ZERO_COUNT;
        end else begin
          run_count_next     = in_ch.data_byte;
          count_pending_next = 1'b1;
        end
      end else begin
        count_pending_next = 1'b0;
        cmd_push           = 1'b1;
        if (run_sum > {1'b0, size_target}) begin
          cmd.status      = ST_EXCEEDS;
          error_code_next = ST_EXCEEDS;
        end else begin
          cmd.is_run       = 1'b1;
          total_count_next = run_sum[TOTAL_W-1:0];
          run_count_next   = '0;
        end
      end
    end
  end

  // Stream state and size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_target   <= '0;
      count_pending <= 1'b0;
      run_count     <= '0;
      total_count   <= '0;
      error_code    <= ST_RUNNING;
    end else begin
      if (cfg_we) begin
        size_target <= cfg_data;
      end
      count_pending <= count_pending_next;
      run_count     <= run_count_next;
      total_count   <= total_count_next;
      error_code    <= error_code_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/brpd_queue.sv
// Short command queue between classifier and expander.
`default_nettype none

module brpd_queue import brpd_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      wdata,
  output logic      full,
  output logic      rvalid,
  output cmd_t      rdata,
  input  wire logic pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full   = (fill == CNT_W'(DEPTH));
  assign rvalid = (fill != '0);
  assign rdata  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> hdl/brpd_back.sv
// Expander: turns commands into result words, one word per cycle while the output accepts them.
`default_nettype none

module brpd_back import brpd_pkg::*; #(
  parameter int BYTES_PER_WORD = DEF_BYTES_PER_WORD
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  brpd_out_if.source out_ch
);

  localparam logic [BYTE_W-1:0] BPW_B = BYTE_W'(BYTES_PER_WORD);
  localparam int LANES = WORD_W / BYTE_W;

  cmd_t               cur;
  logic               cur_valid;
  logic [BYTE_W-1:0]  left;
  logic [TOTAL_W-1:0] run_total;
  logic               emit, last_word, done;
  logic [NBYTE_W-1:0] nbytes;
  logic [WORD_W-1:0]  word;

  assign emit      = cur_valid && (!out_ch.valid || out_ch.ready);
  assign last_word = (left <= BPW_B);
  assign nbytes    = last_word ? left[NBYTE_W-1:0] : BPW_B[NBYTE_W-1:0];
  assign done      = emit && (!cur.is_run || last_word);
  assign cmd_pop   = cmd_valid && (!cur_valid || done);

  // Replicate the value into the valid lanes
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      word[BYTE_W*i +: BYTE_W] = (NBYTE_W'(i) < nbytes) ? cur.value : '0;
    end
  end

  // Current command and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (cmd_pop) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
    end
  end

  // Run progress and output word
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur       <= cmd;
      left      <= cmd.count;
      run_total <= cmd.total;
    end else if (emit && cur.is_run) begin
      left      <= left - {{(BYTE_W-NBYTE_W){1'b0}}, nbytes};
      run_total <= run_total + {{(TOTAL_W-NBYTE_W){1'b0}}, nbytes};
    end
    if (emit) begin
      if (cur.is_run) begin
        out_ch.data_word   <= word;
        out_ch.byte_count  <= nbytes;
        out_ch.run_last    <= last_word;
        out_ch.status      <= ST_RUNNING;
        out_ch.total_bytes <= run_total + {{(TOTAL_W-NBYTE_W){1'b0}}, nbytes};
      end else begin
        out_ch.data_word   <= '0;
        out_ch.byte_count  <= '0;
        out_ch.run_last    <= 1'b1;
        out_ch.status      <= cur.status;
        out_ch.total_bytes <= cur.total;
      end
    end
  end

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the byte run-length pair decoder.
module testbench;
  import brpd_pkg::*;

  localparam logic FUNC_DATA      = 1'b0;
  localparam logic FUNC_END       = 1'b1;
  localparam int   WORD_BYTES     = DEF_BYTES_PER_WORD;
  localparam int   RANDOM_ITEMS   = 330;
  localparam int   CALM_ITEMS     = 60;    // closing stretch runs with no idling
  localparam int   SETTLE_CYCLES  = 24;    // covers queue plus expander latency
  localparam int   WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [WORD_W-1:0]  data_word;
    logic [NBYTE_W-1:0] byte_count;
    logic               run_last;
    logic [STAT_W-1:0]  status;
    logic [TOTAL_W-1:0] total_bytes;
  } out_word_t;

  // Decoder state mirror and queue of words still to come out
  class rle_checker;
    out_word_t          expected_words[$];
    int unsigned        errors;
    int unsigned        items_seen;
    logic [TOTAL_W-1:0] size_limit;
    bit                 count_held;
    logic [BYTE_W-1:0]  held_count;
    logic [TOTAL_W-1:0] total_so_far;
    logic [STAT_W-1:0]  sticky_status;

    function new();
      errors     = 0;
      items_seen = 0;
      size_limit = '0;
      clear_stream();
    endfunction

    function void clear_stream();
      count_held    = 1'b0;
      held_count    = '0;
      total_so_far  = '0;
      sticky_status = ST_RUNNING;
    endfunction

    function void set_size(logic [TOTAL_W-1:0] value);
      size_limit = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void expect_word(logic [WORD_W-1:0] word, logic [NBYTE_W-1:0] nbytes,
                              logic last, logic [STAT_W-1:0] status);
      out_word_t w;
      w.data_word   = word;
      w.byte_count  = nbytes;
      w.run_last    = last;
      w.status      = status;
      w.total_bytes = total_so_far;
      expected_words.insert(expected_words.size(), w);
    endfunction

    // Note one accepted input word and queue the words it should produce
    function void take_byte(logic func, logic [BYTE_W-1:0] value);
      logic [STAT_W-1:0] outcome;
      int unsigned       left;
      int unsigned       n;
      logic [WORD_W-1:0] word;
      items_seen++;
      if (func == FUNC_END) begin
        if (sticky_status != ST_RUNNING) outcome = sticky_status;
        else if (count_held) outcome = ST_TRUNCATED;
        else if (total_so_far != size_limit) outcome = ST_MISMATCH;
        else outcome = ST_DONE_OK;
        expect_word('0, '0, 1'b1, outcome);
        clear_stream();
        return;
      end
      // data is dropped silently once the stream has failed
      if (sticky_status != ST_RUNNING) return;
      if (size_limit == 0) begin
        sticky_status = ST_EXCEEDS;
        expect_word('0, '0, 1'b1, sticky_status);
        return;
      end
      if (!count_held) begin
        if (value == 0) begin
          sticky_status = ST_ZERO_COUNT;
          expect_word('0, '0, 1'b1, sticky_status);
          return;
        end
        held_count = value;
        count_held = 1'b1;
        return;
      end
      count_held = 1'b0;
      if ({1'b0, total_so_far} + held_count > {1'b0, size_limit}) begin
        sticky_status = ST_EXCEEDS;
        expect_word('0, '0, 1'b1, sticky_status);
        return;
      end
      // expand the run, lowest byte first
      left = held_count;
      while (left > 0) begin
        n    = (left > WORD_BYTES) ? WORD_BYTES : left;
        word = '0;
        for (int i = 0; i < n; i++) word[8*i +: 8] = value;
        left         -= n;
        total_so_far += n;
        expect_word(word, n[NBYTE_W-1:0], left == 0, ST_RUNNING);
      end
      held_count = '0;
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, field, want, got);
      end
    endfunction

    // Check one accepted output word against the oldest expectation
    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none got %h", $time, got);
        return;
      end
      want = expected_words.pop_front();
      compare("data_word", want.data_word, got.data_word);
      compare("byte_count", want.byte_count, got.byte_count);
      compare("run_last", want.run_last, got.run_last);
      compare("status", want.status, got.status);
      compare("total_bytes", want.total_bytes, got.total_bytes);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  bit          idle_on;
  int unsigned quiet_cycles = 0;
  rle_checker  sb;

  brpd_in_if  in_ch();
  brpd_out_if out_ch();

  byte_rle_pair_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watch both channels and the register port at each edge
  always @(posedge clk) begin : monitor
    out_word_t seen;
    if (!rst) begin
      if (cfg_we) sb.set_size(cfg_data);
      if (in_ch.valid && in_ch.ready) sb.take_byte(in_ch.func, in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.data_word, out_ch.byte_count, out_ch.run_last,
                out_ch.status, out_ch.total_bytes};
        sb.check_word(seen);
      end
    end
    if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Output back-pressure in random bursts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Present one word, with an optional gap first, and wait for it to be taken
  task automatic send_item(logic func, logic [BYTE_W-1:0] value);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.data_byte <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_pair(logic [BYTE_W-1:0] count, logic [BYTE_W-1:0] value);
    send_item(FUNC_DATA, count);
    send_item(FUNC_DATA, value);
  endtask

  task automatic end_stream();
    send_item(FUNC_END, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Register write, only once the decoder has gone quiet
  task automatic write_size(logic [31:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // One random stream: mostly well-formed, some with a fault or plain noise
  task automatic run_random_stream();
    int unsigned       pairs;
    int unsigned       kind;
    int unsigned       sum;
    logic [BYTE_W-1:0] counts[6];
    logic [BYTE_W-1:0] values[6];
    logic [31:0]       size;
    pairs = $urandom_range(1, 6);
    sum   = 0;
    for (int k = 0; k < pairs; k++) begin
      if ($urandom_range(0, 19) < 3) counts[k] = BYTE_W'($urandom_range(25, 255));
      else counts[k] = BYTE_W'($urandom_range(1, 24));
      values[k] = BYTE_W'($urandom_range(0, 255));
      sum += counts[k];
    end
    kind = $urandom_range(0, 9);
    case (kind)
      6: begin
        // size a little above the sum, or anywhere below it
        if ($urandom_range(0, 1)) size = sum + $urandom_range(1, 20);
        else size = $urandom_range(0, sum - 1);
      end
      9: begin
        if ($urandom_range(0, 1)) size = $urandom;
        else size = $urandom_range(0, 64);
      end
      default: size = sum;
    endcase
    if (kind == 7) counts[$urandom_range(0, pairs - 1)] = '0;
    if (kind <= 5 || $urandom_range(0, 3) != 0) write_size(size);
    if (kind == 9) begin
      repeat ($urandom_range(1, 12))
        send_item($urandom_range(0, 3) == 0, BYTE_W'($urandom_range(0, 255)));
    end else begin
      for (int k = 0; k < pairs; k++) begin
        send_item(FUNC_DATA, counts[k]);
        // truncated streams lose their last value byte
        if (!(kind == 8 && k == pairs - 1)) send_item(FUNC_DATA, values[k]);
      end
    end
    end_stream();
  endtask

  initial begin
    int unsigned base;
    sb              = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_DATA;
    in_ch.data_byte = '0;
    idle_on         = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Size zero after reset: any data fails, later data is dropped
    send_item(FUNC_DATA, 8'h81);
    send_item(FUNC_DATA, 8'h7E);
    end_stream();
    end_stream();

    // Largest size: longest run, one-byte run, exact and split words, dangling count
    write_size(32'hFFFF_FFFF);
    send_pair(8'd255, 8'hA5);
    send_pair(8'd1, 8'h00);
    send_pair(8'd8, 8'hFF);
    send_pair(8'd9, 8'h5A);
    send_item(FUNC_DATA, 8'd3);
    end_stream();

    // Small size: zero count, exact fit, overrun, short total
    write_size(32'd10);
    send_item(FUNC_DATA, 8'd0);
    end_stream();
    send_pair(8'd10, 8'h3C);
    end_stream();
    send_pair(8'd5, 8'hC3);
    send_pair(8'd6, 8'h99);
    end_stream();
    send_pair(8'd4, 8'h66);
    end_stream();

    base = sb.items_seen;
    while (sb.items_seen - base < RANDOM_ITEMS) begin
      idle_on = (sb.items_seen - base < RANDOM_ITEMS - CALM_ITEMS) &&
                ($urandom_range(0, 3) != 0);
      run_random_stream();
    end

    // Drain, then allow for anything still in flight
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
hdl/brpd_pkg.sv
hdl/brpd_if.sv
hdl/brpd_front.sv
hdl/brpd_queue.sv
hdl/brpd_back.sv
hdl/byte_rle_pair_decoder.sv
dv/testbench.sv
